### rtl/lobm_pkg.sv
`timescale 1ns / 1ps
package lobm_pkg;
    localparam int PRICE_LEVELS_DEF = 8;
    localparam int ORDERS_PER_LEVEL_DEF = 4;
    localparam int QTY_BITS = 16;
    localparam int PRICE_BITS = 3;
    localparam int QTY_W = QTY_BITS;
    localparam int TAG_W = 16;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_FILL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_FILL,
        ST_SCAN,
        ST_REST,
        ST_OUT
    } lobm_state_t;

    typedef struct packed {
        logic                  side;
        logic [PRICE_BITS-1:0] price_tick;
        logic [QTY_W-1:0]      quantity;
        logic [TAG_W-1:0]      order_tag;
    } order_t;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [PRICE_BITS-1:0] fill_price;
        logic [QTY_W-1:0]      fill_quantity;
        logic [TAG_W-1:0]      resting_tag;
        logic                  resting_done;
        logic [QTY_W-1:0]      incoming_left;
        logic                  last;
    } result_t;
endpackage

### rtl/lobm_if.sv
`timescale 1ns / 1ps
interface lobm_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/limit_order_book_matcher.sv
`timescale 1ns / 1ps
// Limit order book matcher with price-time priority. Each order transaction is
// worked by a small sequencer. Every resting order touched passes through a check,
// a read, a fill and the output state. When a fill empties the best opposite level,
// a scan follows that visits that side's price levels one by one until it finds
// an occupied level or reaches the end of the side. The closing rest or reject
// passes through a check, a rest state and the output state, and the idle state
// accepts the next order. Each result waits in the output register until taken,
// and the input is not ready while an order is in progress. An order of zero
// quantity is taken in the idle state and produces no result.
module limit_order_book_matcher #(
    parameter int PRICE_LEVELS = lobm_pkg::PRICE_LEVELS_DEF,
    parameter int ORDERS_PER_LEVEL = lobm_pkg::ORDERS_PER_LEVEL_DEF
) (
    input logic clk,
    input logic rst_n,
    lobm_if.sink   orders,
    lobm_if.source results
);
    import lobm_pkg::*;

    localparam int NLEV = 2 * PRICE_LEVELS;
    localparam int NSLOT = NLEV * ORDERS_PER_LEVEL;
    localparam int LW = $clog2(NLEV);
    localparam int HW = (ORDERS_PER_LEVEL > 1) ? $clog2(ORDERS_PER_LEVEL) : 1;
    localparam int CW = $clog2(ORDERS_PER_LEVEL + 1);
    localparam int SW = $clog2(NSLOT);
    localparam int TW = QTY_BITS + 2;
    localparam int TOP_TICK = (PRICE_LEVELS < 2 ** PRICE_BITS) ? PRICE_LEVELS - 1
                                                               : 2 ** PRICE_BITS - 1;

    logic [QTY_BITS-1:0] rq_mem [NSLOT];
    logic [TAG_W-1:0]    tag_mem [NSLOT];
    logic [HW-1:0]       head_reg [NLEV];
    logic [CW-1:0]       count_reg [NLEV];
    logic [TW-1:0]       total_reg [NLEV];
    logic [PRICE_BITS-1:0] top_bid_reg, top_ask_reg;
    logic bid_present_reg, ask_present_reg;

    lobm_state_t state_reg, state_next;
    order_t ord_reg;
    logic [QTY_BITS-1:0] rem_reg;
    logic [PRICE_BITS-1:0] lvl_reg, scan_reg;
    logic [QTY_BITS-1:0] rd_q_reg;
    logic [TAG_W-1:0] rd_tag_reg;
    result_t res_reg;
    logic out_valid_reg;
    logic fill_taken_reg;
    logic scan_pending_reg;

    order_t in_ord;
    logic [PRICE_BITS-1:0] p_sat;
    logic opp;
    logic [LW-1:0] own_li, scan_li, lidx;
    logic [SW-1:0] head_slot, tail_slot, wr_slot;
    logic crosses;
    logic [QTY_BITS-1:0] take;
    logic done;
    logic level_full;

    assign in_ord = orders.data;
    assign orders.ready = (state_reg == ST_IDLE);
    assign results.valid = out_valid_reg;
    assign results.data = res_reg;

    assign opp = ~ord_reg.side;
    assign lidx = LW'(32'(opp) * PRICE_LEVELS + 32'(lvl_reg));
    assign own_li = LW'(32'(ord_reg.side) * PRICE_LEVELS + 32'(ord_reg.price_tick));
    assign scan_li = LW'(32'(opp) * PRICE_LEVELS + 32'(scan_reg));
    assign head_slot = SW'(32'(lidx) * ORDERS_PER_LEVEL + 32'(head_reg[lidx]));
    assign tail_slot = SW'(32'(own_li) * ORDERS_PER_LEVEL
        + ((32'(head_reg[own_li]) + 32'(count_reg[own_li]) >= ORDERS_PER_LEVEL)
            ? 32'(head_reg[own_li]) + 32'(count_reg[own_li]) - ORDERS_PER_LEVEL
            : 32'(head_reg[own_li]) + 32'(count_reg[own_li])));
    assign wr_slot = (state_reg == ST_FILL) ? head_slot : tail_slot;
    assign take = (rd_q_reg < rem_reg) ? rd_q_reg : rem_reg;
    assign done = (rd_q_reg == take);
    assign level_full = (32'(count_reg[own_li]) >= ORDERS_PER_LEVEL);

    always_comb
    begin
        if (32'(in_ord.price_tick) >= PRICE_LEVELS)
            p_sat = PRICE_BITS'(TOP_TICK);
        else
            p_sat = in_ord.price_tick;
        if (ord_reg.side == 1'b0)
            crosses = ask_present_reg && (top_ask_reg <= ord_reg.price_tick);
        else
            crosses = bid_present_reg && (ord_reg.price_tick <= top_bid_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (orders.valid && in_ord.quantity[QTY_BITS-1:0] != '0)
                    state_next = ST_CHECK;
            ST_CHECK:
                if (rem_reg == '0)
                    state_next = ST_IDLE;
                else if (crosses)
                    state_next = ST_READ;
                else
                    state_next = ST_REST;
            ST_READ: state_next = ST_FILL;
            ST_FILL: state_next = ST_OUT;
            ST_SCAN:
                if (count_reg[scan_li] != '0 || (opp ? (32'(scan_reg) == TOP_TICK)
                                                     : (scan_reg == '0)))
                    state_next = ST_CHECK;
            ST_REST: state_next = ST_OUT;
            ST_OUT:
                if (out_valid_reg && results.ready)
                begin
                    if (scan_pending_reg)
                        state_next = ST_SCAN;
                    else if (res_reg.last)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_CHECK;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            rd_q_reg <= rq_mem[head_slot];
            rd_tag_reg <= tag_mem[head_slot];
        end
        if (state_reg == ST_FILL || (state_reg == ST_REST && !level_full))
            rq_mem[wr_slot] <= (state_reg == ST_FILL) ? rd_q_reg - take : rem_reg;
        if (state_reg == ST_REST && !level_full)
            tag_mem[tail_slot] <= ord_reg.order_tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            top_bid_reg <= '0;
            top_ask_reg <= '0;
            bid_present_reg <= 1'b0;
            ask_present_reg <= 1'b0;
            scan_pending_reg <= 1'b0;
            for (int i = 0; i < NLEV; i++)
            begin
                head_reg[i] <= '0;
                count_reg[i] <= '0;
                total_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && results.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (orders.valid)
                    begin
                        ord_reg <= {in_ord.side, p_sat, in_ord.quantity, in_ord.order_tag};
                        rem_reg <= in_ord.quantity[QTY_BITS-1:0];
                    end
                ST_CHECK:
                    lvl_reg <= ord_reg.side ? top_bid_reg : top_ask_reg;
                ST_FILL:
                begin
                    rem_reg <= rem_reg - take;
                    total_reg[lidx] <= total_reg[lidx] - TW'(take);
                    res_reg.kind <= KIND_FILL;
                    res_reg.fill_price <= lvl_reg;
                    res_reg.fill_quantity <= QTY_W'(take);
                    res_reg.resting_tag <= rd_tag_reg;
                    res_reg.resting_done <= done;
                    res_reg.incoming_left <= QTY_W'(rem_reg - take);
                    res_reg.last <= (rem_reg == take);
                    if (done)
                    begin
                        head_reg[lidx] <= (32'(head_reg[lidx]) == ORDERS_PER_LEVEL - 1)
                            ? '0 : head_reg[lidx] + 1'b1;
                        count_reg[lidx] <= count_reg[lidx] - 1'b1;
                        if (count_reg[lidx] == CW'(1))
                        begin
                            scan_pending_reg <= 1'b1;
                            scan_reg <= opp ? '0 : PRICE_BITS'(TOP_TICK);
                        end
                    end
                    out_valid_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    if (count_reg[scan_li] != '0)
                    begin
                        scan_pending_reg <= 1'b0;
                        if (opp) begin ask_present_reg <= 1'b1; top_ask_reg <= scan_reg; end
                        else begin bid_present_reg <= 1'b1; top_bid_reg <= scan_reg; end
                    end
                    else if (opp ? (32'(scan_reg) == TOP_TICK) : (scan_reg == '0))
                    begin
                        scan_pending_reg <= 1'b0;
                        if (opp) begin ask_present_reg <= 1'b0; top_ask_reg <= '0; end
                        else begin bid_present_reg <= 1'b0; top_bid_reg <= '0; end
                    end
                    else
                        scan_reg <= opp ? scan_reg + 1'b1 : scan_reg - 1'b1;
                end
                ST_REST:
                begin
                    res_reg.fill_price <= ord_reg.price_tick;
                    res_reg.fill_quantity <= QTY_W'(rem_reg);
                    res_reg.resting_tag <= '0;
                    res_reg.resting_done <= 1'b0;
                    res_reg.incoming_left <= QTY_W'(rem_reg);
                    res_reg.last <= 1'b1;
                    rem_reg <= '0;
                    if (level_full)
                        res_reg.kind <= KIND_REJECTED;
                    else
                    begin
                        res_reg.kind <= KIND_RESTED;
                        count_reg[own_li] <= count_reg[own_li] + 1'b1;
                        total_reg[own_li] <= total_reg[own_li] + TW'(rem_reg);
                        if (!ord_reg.side)
                        begin
                            if (!bid_present_reg || ord_reg.price_tick > top_bid_reg)
                                top_bid_reg <= ord_reg.price_tick;
                            bid_present_reg <= 1'b1;
                        end
                        else
                        begin
                            if (!ask_present_reg || ord_reg.price_tick < top_ask_reg)
                                top_ask_reg <= ord_reg.price_tick;
                            ask_present_reg <= 1'b1;
                        end
                    end
                    out_valid_reg <= 1'b0;
                end
                ST_OUT:
                    if (!fill_taken_reg)
                        out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_taken_reg <= 1'b0;
        else if (state_reg == ST_OUT && !out_valid_reg && !fill_taken_reg)
            fill_taken_reg <= 1'b1;
        else if (state_reg != ST_OUT)
            fill_taken_reg <= 1'b0;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == ST_OUT)
        else $error("result shown outside output state");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FILL |-> rem_reg != '0)
        else $error("fill with nothing left");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |=> out_valid_reg && $stable(res_reg))
        else $error("result dropped");
endmodule

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import lobm_pkg::*;

    localparam int ORDER_W = $bits(order_t);
    localparam int RESULT_W = $bits(result_t);
    localparam int NLEV = 2 * PRICE_LEVELS_DEF;
    localparam int NSLOT = NLEV * ORDERS_PER_LEVEL_DEF;
    localparam int RANDOM_ORDERS = 310;

    logic clk;
    logic rst_n;

    lobm_if #(.W(ORDER_W)) orders ();
    lobm_if #(.W(RESULT_W)) results ();

    limit_order_book_matcher dut (
        .clk(clk),
        .rst_n(rst_n),
        .orders(orders),
        .results(results)
    );

    class book_scoreboard;
        logic [QTY_W-1:0] slot_qty[NSLOT];
        logic [TAG_W-1:0] slot_tag[NSLOT];
        int head[NLEV];
        int count[NLEV];
        int top_bid;
        int top_ask;
        bit bid_on;
        bit ask_on;
        result_t pending_fills[$];
        int mismatches;

        function new();
            for (int i = 0; i < NSLOT; i++)
            begin
                slot_qty[i] = '0;
                slot_tag[i] = '0;
            end
            for (int i = 0; i < NLEV; i++)
            begin
                head[i] = 0;
                count[i] = 0;
            end
            top_bid = 0;
            top_ask = 0;
            bid_on = 0;
            ask_on = 0;
            mismatches = 0;
        endfunction

        function void find_best(int s);
            if (s == 0)
            begin
                bid_on = 0;
                top_bid = 0;
                for (int l = PRICE_LEVELS_DEF - 1; l >= 0; l--)
                    if (!bid_on && count[l] != 0)
                    begin
                        bid_on = 1;
                        top_bid = l;
                    end
            end
            else
            begin
                ask_on = 0;
                top_ask = 0;
                for (int l = 0; l < PRICE_LEVELS_DEF; l++)
                    if (!ask_on && count[PRICE_LEVELS_DEF + l] != 0)
                    begin
                        ask_on = 1;
                        top_ask = l;
                    end
            end
        endfunction

        function void note_order(order_t o);
            int p;
            int li;
            int slot;
            int lvl;
            logic [QTY_W-1:0] rem;
            logic [QTY_W-1:0] take;
            result_t r;
            int first;
            p = (o.price_tick >= PRICE_LEVELS_DEF) ? PRICE_LEVELS_DEF - 1 : o.price_tick;
            rem = o.quantity;
            first = pending_fills.size();
            if (rem == 0)
                return;
            forever
            begin
                if (o.side == 0)
                begin
                    if (!ask_on || top_ask > p)
                        break;
                    lvl = top_ask;
                end
                else
                begin
                    if (!bid_on || p > top_bid)
                        break;
                    lvl = top_bid;
                end
                li = (o.side ? 0 : PRICE_LEVELS_DEF) + lvl;
                if (count[li] == 0)
                begin
                    find_best(o.side ? 0 : 1);
                    continue;
                end
                slot = li * ORDERS_PER_LEVEL_DEF + head[li];
                take = (slot_qty[slot] < rem) ? slot_qty[slot] : rem;
                slot_qty[slot] -= take;
                rem -= take;
                r = '0;
                r.kind = KIND_FILL;
                r.fill_price = PRICE_BITS'(lvl);
                r.fill_quantity = take;
                r.resting_tag = slot_tag[slot];
                r.resting_done = (slot_qty[slot] == 0);
                r.incoming_left = rem;
                pending_fills = {pending_fills, r};
                if (r.resting_done)
                begin
                    head[li] = (head[li] + 1) % ORDERS_PER_LEVEL_DEF;
                    count[li]--;
                    if (count[li] == 0)
                        find_best(o.side ? 0 : 1);
                end
                if (rem == 0)
                    break;
            end
            if (rem != 0)
            begin
                li = o.side * PRICE_LEVELS_DEF + p;
                r = '0;
                r.fill_price = PRICE_BITS'(p);
                r.fill_quantity = rem;
                r.incoming_left = rem;
                if (count[li] >= ORDERS_PER_LEVEL_DEF)
                    r.kind = KIND_REJECTED;
                else
                begin
                    slot = li * ORDERS_PER_LEVEL_DEF
                        + (head[li] + count[li]) % ORDERS_PER_LEVEL_DEF;
                    slot_qty[slot] = rem;
                    slot_tag[slot] = o.order_tag;
                    count[li]++;
                    if (o.side == 0)
                    begin
                        if (!bid_on || p > top_bid)
                            top_bid = p;
                        bid_on = 1;
                    end
                    else
                    begin
                        if (!ask_on || p < top_ask)
                            top_ask = p;
                        ask_on = 1;
                    end
                    r.kind = KIND_RESTED;
                end
                pending_fills = {pending_fills, r};
            end
            if (pending_fills.size() > first)
                pending_fills[pending_fills.size() - 1].last = 1'b1;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_fills.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = pending_fills.pop_front();
            if (got.kind !== want.kind || got.fill_price !== want.fill_price
                || got.fill_quantity !== want.fill_quantity
                || got.resting_tag !== want.resting_tag
                || got.resting_done !== want.resting_done
                || got.incoming_left !== want.incoming_left
                || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    book_scoreboard board;
    bit quiet_tail;
    bit hold_results;
    bit start_hold;
    bit stimulus_done;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic send_order(input order_t o);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            orders.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        orders.valid <= 1'b1;
        orders.data <= o;
        do
            @(posedge clk);
        while (!orders.ready);
        board.note_order(o);
        @(negedge clk);
    endtask

    task automatic send_fields(input bit s, input int p, input int q, input int t);
        order_t o;
        o.side = s;
        o.price_tick = PRICE_BITS'(p);
        o.quantity = QTY_W'(q);
        o.order_tag = TAG_W'(t);
        send_order(o);
    endtask

    function automatic order_t random_order();
        order_t o;
        o.side = 1'($urandom_range(0, 1));
        o.price_tick = PRICE_BITS'($urandom_range(2, 5));
        if ($urandom_range(0, 4) == 0)
            o.price_tick = PRICE_BITS'($urandom_range(0, 7));
        case ($urandom_range(0, 5))
            0: o.quantity = QTY_W'($urandom);
            1: o.quantity = 16'hffff;
            2: o.quantity = '0;
            default: o.quantity = QTY_W'($urandom_range(1, 400));
        endcase
        o.order_tag = TAG_W'($urandom);
        return o;
    endfunction

    initial
    begin
        board = new();
        rst_n = 1'b0;
        orders.valid = 1'b0;
        orders.data = '0;
        quiet_tail = 0;
        start_hold = 0;
        stimulus_done = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_fields(0, 3, 100, 16'h0001);
        send_fields(0, 3, 200, 16'hffff);
        send_fields(0, 3, 16'hffff, 16'h00aa);
        send_fields(0, 3, 5, 16'h5555);
        send_fields(0, 3, 7, 16'h1234);
        send_fields(1, 7, 9, 16'h0bad);
        send_fields(1, 3, 150, 16'haaaa);
        send_fields(1, 0, 16'hffff, 16'h0f0f);
        send_fields(1, 0, 0, 16'hffff);
        send_fields(1, 0, 50, 16'h0002);
        send_fields(1, 0, 60, 16'h0003);
        send_fields(1, 0, 70, 16'h0004);
        send_fields(1, 0, 80, 16'h0005);
        send_fields(0, 7, 1, 16'h8000);
        send_fields(0, 7, 16'hffff, 16'h7fff);
        send_fields(0, 0, 1, 16'h0006);
        send_fields(1, 7, 3, 16'h0007);
        send_fields(0, 6, 2, 16'h0008);
        start_hold = 1;
        for (int i = 0; i < RANDOM_ORDERS; i++)
        begin
            if (i > RANDOM_ORDERS - 40)
                quiet_tail = 1;
            send_order(random_order());
        end
        orders.valid <= 1'b0;
        stimulus_done = 1;
    end

    initial
    begin
        int hold_cycles;
        hold_results = 0;
        wait (start_hold);
        hold_results = 1;
        hold_cycles = 300;
        while (hold_cycles > 0)
        begin
            @(negedge clk);
            hold_cycles--;
        end
        hold_results = 0;
    end

    initial
    begin
        results.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
                results.ready <= 1'b0;
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                results.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                results.ready <= 1'b1;
            end
            else
                results.ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && results.valid && results.ready)
            board.check_result(results.data);

    initial
    begin
        wait (stimulus_done);
        while (board.pending_fills.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.mismatches == 0 && board.pending_fills.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("simulation failed");
        $finish;
    end
endmodule
